// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the vector distance engine modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, quiet while reset is high
`define VDE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies another one on the next clock edge
`define VDE_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- hdl/vde_pkg.sv -----
// ----------------------------------------------------------------------------
// vde_pkg
// Shared constants, metric codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vde_pkg;

   // Vector length and accumulator formats
   localparam int MAX_LEN    = 4096;
   localparam int CNT_W      = 13;
   localparam int CNT_MAX    = 8191;
   localparam int LEN_LIMIT  = (MAX_LEN < CNT_MAX) ? MAX_LEN : CNT_MAX;
   localparam int ELEM_W     = 16;
   localparam int MAG_W      = 16;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int CUM_W      = 29;
   localparam int ACC_W      = 50;
   localparam int FRAC_SHIFT = 8;
   localparam int QUOT_SHIFT = 16;

   // Restoring divider: one quotient bit per cycle
   localparam int NUM_W      = CNT_W + QUOT_SHIFT;
   localparam int DIV_CNT_W  = $clog2(NUM_W);

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int METRIC_W   = 3;

   // Metric codes
   localparam logic [METRIC_W-1:0] METRIC_SQ_EUCLID = 3'd0;
   localparam logic [METRIC_W-1:0] METRIC_CITY      = 3'd1;
   localparam logic [METRIC_W-1:0] METRIC_CHEBYSHEV = 3'd2;
   localparam logic [METRIC_W-1:0] METRIC_HAMMING   = 3'd3;
   localparam logic [METRIC_W-1:0] METRIC_JACCARD   = 3'd4;
   localparam logic [METRIC_W-1:0] METRIC_EMD       = 3'd5;

   // Controller states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_STEP   = 6'b000010,
      ST_FORM   = 6'b000100,
      ST_ACCUM  = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic step;
      logic form;
      logic accum;
      logic div_start;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last;
      logic need_div;
      logic out_free;
   } stat_type;

endpackage

// ----- hdl/vector_distance_engine.sv -----
// ----------------------------------------------------------------------------
// vector_distance_engine
// Streams element pairs of two vectors and returns one distance per vector
// under the metric chosen in the register port.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_elem_a, req_elem_b, req_last
// rsp       out        rsp_valid / rsp_stall   rsp_distance, rsp_status
// csr       in/out     psel, penable, pready   paddr, pwrite, pwdata, prdata
//
// A pair walks the controller through accept, step, form and accumulate.
// A last pair adds a finish state, and for Hamming and Jaccard a divide state
// in which the divider resolves one quotient bit per cycle.
// The finish cycle waits while the output register holds an untaken result.
// Synchronous reset clears the metric register, all accumulators and valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_distance_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [vde_pkg::ELEM_W-1:0]     req_elem_a,
   input  logic signed [vde_pkg::ELEM_W-1:0]     req_elem_b,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [vde_pkg::ACC_W-1:0]             rsp_distance,
   output logic                                  rsp_status,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [vde_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [vde_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [vde_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import vde_pkg::*;

   cmd_type               cmd;
   stat_type              stat;
   logic [METRIC_W-1:0]   metric_ff;
   logic                  metric_sel;

   // Register decode: the metric register answers at words zero to three
   assign metric_sel = (paddr[CSR_ADDR_W-1] == 1'b0);
   assign pready     = 1'b1;
   assign prdata     = metric_sel ? CSR_DATA_W'(metric_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= METRIC_SQ_EUCLID;
      end else if (psel && penable && pwrite && pready && metric_sel) begin
         metric_ff <= pwdata[METRIC_W-1:0];
      end
   end

   vde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   vde_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .metric       (metric_ff),
      .req_elem_a   (req_elem_a),
      .req_elem_b   (req_elem_b),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_distance (rsp_distance),
      .rsp_status   (rsp_status)
   );

endmodule

// ----- hdl/vde_ctrl.sv -----
// ----------------------------------------------------------------------------
// vde_ctrl
// Sequencer: walks each request through step, form and accumulate, runs the
// divider for fraction metrics and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vde_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  vde_pkg::stat_type  stat,
   output vde_pkg::cmd_type   cmd
);
   import vde_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            state_in = ST_FORM;
         end
         ST_FORM: begin
            cmd.form = 1'b1;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            if (!stat.last) begin
               state_in = ST_IDLE;
            end else if (stat.need_div) begin
               cmd.div_start = 1'b1;
               div_cnt_in    = '0;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               div_cnt_in = '0;
               state_in   = ST_FINISH;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `VDE_ASSERT(div_cnt_idle_chk, (state_ff != ST_DIVIDE) |-> (div_cnt_ff == '0), "divide counter active outside divide")
   `VDE_ASSERT_NEXT(div_start_chk, cmd.div_start, (state_ff == ST_DIVIDE) && (div_cnt_ff == '0), "divider did not start cleanly")

endmodule

// ----- hdl/vde_datapath.sv -----
// ----------------------------------------------------------------------------
// vde_datapath
// Element registers, running accumulators, serial divider and the result
// register of the vector distance engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vde_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  vde_pkg::cmd_type                      cmd,
   output vde_pkg::stat_type                     stat,
   input  logic [vde_pkg::METRIC_W-1:0]          metric,
   input  logic signed [vde_pkg::ELEM_W-1:0]     req_elem_a,
   input  logic signed [vde_pkg::ELEM_W-1:0]     req_elem_b,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [vde_pkg::ACC_W-1:0]             rsp_distance,
   output logic                                  rsp_status
);
   import vde_pkg::*;

   // Clamp a running sum to the signed prefix-sum range
   function automatic logic [CUM_W-1:0] sat_cum(input logic [CUM_W:0] s);
      logic [CUM_W-1:0] r;
      if (s[CUM_W] != s[CUM_W-1]) begin
         r = s[CUM_W] ? {1'b1, {(CUM_W-1){1'b0}}} : {1'b0, {(CUM_W-1){1'b1}}};
      end else begin
         r = s[CUM_W-1:0];
      end
      return r;
   endfunction

   logic signed [ELEM_W-1:0] a_ff, b_ff;
   logic                     last_ff;
   logic                     take_ff, take_in;
   logic [MAG_W-1:0]         mag_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic [ACC_W-1:0]         term_ff, term_in;
   logic [ACC_W-1:0]         accum_ff, accum_in;
   logic [CNT_W-1:0]         pair_cnt_ff, nonzero_cnt_ff, mismatch_cnt_ff;
   logic [CUM_W-1:0]         cum_a_ff, cum_b_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [CNT_W-1:0]         rem_ff, den_ff;
   logic                     rsp_valid_ff;
   logic [ACC_W-1:0]         rsp_distance_ff, rsp_distance_in;
   logic                     rsp_status_ff, rsp_status_in;

   logic [ELEM_W:0]          diff;
   logic [ELEM_W:0]          diff_mag;
   logic [CUM_W:0]           cum_a_sum, cum_b_sum;
   logic [CUM_W:0]           emd_diff, emd_mag;
   logic [ACC_W:0]           acc_sum;
   logic [CNT_W:0]           rem_shift;
   logic                     rem_ge;

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         a_ff    <= req_elem_a;
         b_ff    <= req_elem_b;
         last_ff <= req_last;
      end
   end

   // Element difference and prefix sums
   always_comb begin
      diff      = {b_ff[ELEM_W-1], b_ff} - {a_ff[ELEM_W-1], a_ff};
      diff_mag  = diff[ELEM_W] ? (~diff + 1'b1) : diff;
      cum_a_sum = {cum_a_ff[CUM_W-1], cum_a_ff} + {{(CUM_W+1-ELEM_W){a_ff[ELEM_W-1]}}, a_ff};
      cum_b_sum = {cum_b_ff[CUM_W-1], cum_b_ff} + {{(CUM_W+1-ELEM_W){b_ff[ELEM_W-1]}}, b_ff};
      take_in   = (pair_cnt_ff < CNT_W'(LEN_LIMIT));
   end

   // Square the magnitude; register before the accumulate
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         mag_ff  <= diff_mag[MAG_W-1:0];
         prod_ff <= diff_mag[MAG_W-1:0] * diff_mag[MAG_W-1:0];
      end
   end

   // Select the per-pair term
   always_comb begin
      emd_diff = {cum_a_ff[CUM_W-1], cum_a_ff} - {cum_b_ff[CUM_W-1], cum_b_ff};
      emd_mag  = emd_diff[CUM_W] ? (~emd_diff + 1'b1) : emd_diff;
      case (metric)
         METRIC_SQ_EUCLID: term_in = ACC_W'(prod_ff);
         METRIC_CITY:      term_in = ACC_W'({mag_ff, {FRAC_SHIFT{1'b0}}});
         METRIC_CHEBYSHEV: term_in = ACC_W'({mag_ff, {FRAC_SHIFT{1'b0}}});
         METRIC_EMD:       term_in = ACC_W'({emd_mag, {FRAC_SHIFT{1'b0}}});
         default:          term_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.form) begin
         term_ff <= term_in;
      end
   end

   // Saturating add, or running maximum for Chebyshev
   always_comb begin
      acc_sum = {1'b0, accum_ff} + {1'b0, term_ff};
      if (metric == METRIC_CHEBYSHEV) begin
         accum_in = (term_ff > accum_ff) ? term_ff : accum_ff;
      end else begin
         accum_in = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      end
   end

   // Running accumulators: clear after each result
   always_ff @(posedge clock) begin
      if (reset || cmd.load_rsp) begin
         take_ff         <= 1'b0;
         accum_ff        <= '0;
         pair_cnt_ff     <= '0;
         nonzero_cnt_ff  <= '0;
         mismatch_cnt_ff <= '0;
         cum_a_ff        <= '0;
         cum_b_ff        <= '0;
      end else begin
         if (cmd.step) begin
            take_ff <= take_in;
            if (take_in) begin
               pair_cnt_ff <= pair_cnt_ff + 1'b1;
               if ((a_ff != '0) || (b_ff != '0)) begin
                  nonzero_cnt_ff <= nonzero_cnt_ff + 1'b1;
               end
               if (a_ff != b_ff) begin
                  mismatch_cnt_ff <= mismatch_cnt_ff + 1'b1;
               end
               cum_a_ff <= sat_cum(cum_a_sum);
               cum_b_ff <= sat_cum(cum_b_sum);
            end
         end
         if (cmd.accum && take_ff) begin
            accum_ff <= accum_in;
         end
      end
   end

   // Restoring divider, one quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      rem_ge    = (rem_shift >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff <= {mismatch_cnt_ff, {QUOT_SHIFT{1'b0}}};
         rem_ff <= '0;
         den_ff <= (metric == METRIC_JACCARD) ? nonzero_cnt_ff : pair_cnt_ff;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], rem_ge};
         rem_ff <= rem_ge ? CNT_W'(rem_shift - {1'b0, den_ff}) : rem_shift[CNT_W-1:0];
      end
   end

   // Pick the finished distance
   always_comb begin
      rsp_status_in = (metric == METRIC_JACCARD) && (nonzero_cnt_ff == '0);
      case (metric)
         METRIC_SQ_EUCLID,
         METRIC_CITY,
         METRIC_CHEBYSHEV,
         METRIC_EMD:       rsp_distance_in = accum_ff;
         METRIC_HAMMING,
         METRIC_JACCARD:   rsp_distance_in = (den_ff == '0) ? '0 : ACC_W'(num_ff);
         default:          rsp_distance_in = '0;
      endcase
   end

   // Output register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_distance_ff <= rsp_distance_in;
         rsp_status_ff   <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_distance  = rsp_distance_ff;
   assign rsp_status    = rsp_status_ff;
   assign stat.last     = last_ff;
   assign stat.need_div = (metric == METRIC_HAMMING) || (metric == METRIC_JACCARD);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   `VDE_ASSERT(pair_limit_chk, pair_cnt_ff <= CNT_W'(LEN_LIMIT), "pair count past length limit")
   `VDE_ASSERT(count_order_chk, (mismatch_cnt_ff <= nonzero_cnt_ff) && (nonzero_cnt_ff <= pair_cnt_ff), "pair counters out of order")
   `VDE_ASSERT_NEXT(clear_chk, cmd.load_rsp, (pair_cnt_ff == '0) && (accum_ff == '0) && rsp_valid_ff, "state not cleared after result")

endmodule
